>>> hdl/lane_follow_phase_controller_defines.svh
// assertion macros for the lane follow phase controller checker
// no dependencies; included by the checker file only
`ifndef LANE_FOLLOW_PHASE_CONTROLLER_DEFINES_SVH
`define LANE_FOLLOW_PHASE_CONTROLLER_DEFINES_SVH

// generic clocked assertion with asynchronous active-low reset gating
`define LFPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, bound to the block clock and reset
`define LFPC_ASSERT_CLK(lbl, prop, msg) \
  `LFPC_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> hdl/lfpc_pkg.sv
// shared types, codes and constants of the lane follow phase controller
// no dependencies; imported by every module of the block
package lfpc_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_SPEED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_RATE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_TICKS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_RATE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_TICKS       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_THRESHOLD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_SPEED     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_GAIN      = 3'd7;

  // register reset values
  localparam logic [10:0]        RST_FORWARD_SPEED    = 11'd500;
  localparam logic signed [12:0] RST_FORWARD_RATE     = 13'sd300;
  localparam logic [15:0]        RST_FORWARD_TICKS    = 16'd100;
  localparam logic [11:0]        RST_TURN_RATE        = 12'd300;
  localparam logic [15:0]        RST_TURN_TICKS       = 16'd100;
  localparam logic [8:0]         RST_YELLOW_THRESHOLD = 9'd38;
  localparam logic [10:0]        RST_FOLLOW_SPEED     = 11'd400;
  localparam logic [9:0]         RST_FOLLOW_GAIN      = 10'd50;

  // fixed tuning
  localparam logic [10:0] AVOID_SPEED     = 11'd800;
  localparam logic [9:0]  AVOID_GAIN      = 10'd35;
  localparam logic [9:0]  BLACK_GAIN      = 10'd6;
  localparam logic [10:0] BLACK_SPEED     = 11'd800;
  localparam logic [10:0] CONE_BOTTOM_MIN = 11'd190;
  localparam logic [10:0] CONE_BOTTOM_MAX = 11'd480;
  localparam logic [8:0]  CONE_CONF_MIN   = 9'd179;
  localparam logic [11:0] CONE_SPLIT_X2   = 12'd600;
  localparam logic [15:0] SETTLE_TICKS    = 16'd10;
  localparam logic [12:0] RATE_LIMIT      = 13'd8000;
  localparam logic [18:0] ERR_LIMIT       = 19'd524287;

  // image geometry in pixels, Q8 where noted
  localparam logic signed [11:0] BLACK_TARGET_X  = 12'sd370;
  localparam logic signed [11:0] YELLOW_TARGET_X = 12'sd320;
  localparam logic signed [11:0] DEAD_ZONE       = 12'sd5;
  localparam logic signed [20:0] IMG_WIDTH_Q8    = 21'sd163840;

  // reciprocal constants for division by ten
  localparam logic [31:0] RECIP10_32  = 32'hCCCCCCCD;
  localparam logic [12:0] RECIP10_16  = 13'd6554;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_FORWARD = 3'd1,
    PH_TURN    = 3'd2,
    PH_YELLOW  = 3'd3,
    PH_BLACK   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    SIDE_NONE  = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_RIGHT = 2'd2
  } side_e;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_BLACK  = 2'd1,
    MODE_YELLOW = 2'd2,
    MODE_AVOID  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_DECIDE = 3'd1,
    ST_DIV1   = 3'd2,
    ST_FILT   = 3'd3,
    ST_RATE   = 3'd4,
    ST_DIV2   = 3'd5,
    ST_DONE   = 3'd6
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic decide;
    logic div_run;
    logic div_rate;
    logic filt;
    logic rate;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic arith;
    logic rate_div;
    logic out_free;
  } dp_status_t;

endpackage

>>> hdl/lane_follow_phase_controller.sv
// top level of the lane follow phase controller: controller plus datapath
// depends on lfpc_pkg, lfpc_ctrl and lfpc_dp
//
//   channel   handshake              payload
//   in        in_valid_i/in_ready_o  op_i .. cone_height_i
//   out       out_valid_o/out_ready_i cmd_valid_o .. avoiding_o
//   cfg       cfg_we_i               cfg_idx_i, cfg_data_i
//
// an item steps through IDLE, DECIDE and DONE when no filter runs; black-line
// settle adds DIV1, FILT and RATE, and yellow follow or cone avoidance also
// DIV2; the shared divide-by-ten multiplier runs in DIV1 of every filtered
// item, and the yellow and avoid gains need a second pass for the rate in DIV2
// one item is in work at a time; the next one is taken while a result waits
// in the output register, and a full output register holds the item in work
// reset clears phase, tick count, filter errors, avoid side and hold and
// loads the register defaults
module lane_follow_phase_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lfpc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lfpc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic signed [10:0]              black_x_i,
  input  logic signed [10:0]              yellow_x_i,
  input  logic                            ratio_present_i,
  input  logic [8:0]                      yellow_ratio_i,
  input  logic                            cone_present_i,
  input  logic [8:0]                      cone_conf_i,
  input  logic [9:0]                      cone_left_i,
  input  logic [9:0]                      cone_top_i,
  input  logic [9:0]                      cone_width_i,
  input  logic [9:0]                      cone_height_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            cmd_valid_o,
  output logic [10:0]                     linear_speed_o,
  output logic signed [13:0]              angular_rate_o,
  output logic [2:0]                      phase_now_o,
  output logic                            avoiding_o
);
  import lfpc_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // sequencer
  lfpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd),
    .in_ready_o (in_ready_o)
  );

  // arithmetic and state
  lfpc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .status_o        (dp_status),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .op_i            (op_i),
    .black_x_i       (black_x_i),
    .yellow_x_i      (yellow_x_i),
    .ratio_present_i (ratio_present_i),
    .yellow_ratio_i  (yellow_ratio_i),
    .cone_present_i  (cone_present_i),
    .cone_conf_i     (cone_conf_i),
    .cone_left_i     (cone_left_i),
    .cone_top_i      (cone_top_i),
    .cone_width_i    (cone_width_i),
    .cone_height_i   (cone_height_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cmd_valid_o     (cmd_valid_o),
    .linear_speed_o  (linear_speed_o),
    .angular_rate_o  (angular_rate_o),
    .phase_now_o     (phase_now_o),
    .avoiding_o      (avoiding_o)
  );

endmodule

>>> hdl/lfpc_ctrl.sv
// sequencing state machine of the lane follow phase controller
// depends on lfpc_pkg for state codes and command/status structs
module lfpc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  lfpc_pkg::dp_status_t status_i,
  output lfpc_pkg::dp_cmd_t    cmd_o,
  output logic                in_ready_o
);
  import lfpc_pkg::*;

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = status_i.arith ? ST_DIV1 : ST_DONE;
      end
      ST_DIV1: state_d = ST_FILT;
      ST_FILT: state_d = ST_RATE;
      ST_RATE: begin
        state_d = status_i.rate_div ? ST_DIV2 : ST_DONE;
      end
      ST_DIV2: state_d = ST_DONE;
      ST_DONE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DECIDE: cmd_o.decide = 1'b1;
      ST_DIV1:   cmd_o.div_run = 1'b1;
      ST_FILT:   cmd_o.filt = 1'b1;
      ST_RATE:   cmd_o.rate = 1'b1;
      ST_DIV2: begin
        cmd_o.div_run  = 1'b1;
        cmd_o.div_rate = 1'b1;
      end
      ST_DONE:   cmd_o.finish = status_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

>>> hdl/lfpc_dp.sv
// datapath: config registers, phase state, error filters, rate math, output register
// depends on lfpc_pkg; driven by lfpc_ctrl through dp_cmd_t
module lfpc_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lfpc_pkg::dp_cmd_t                      cmd_i,
  output lfpc_pkg::dp_status_t                   status_o,
  input  logic                                  cfg_we_i,
  input  logic [lfpc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [lfpc_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  op_i,
  input  logic signed [10:0]                    black_x_i,
  input  logic signed [10:0]                    yellow_x_i,
  input  logic                                  ratio_present_i,
  input  logic [8:0]                            yellow_ratio_i,
  input  logic                                  cone_present_i,
  input  logic [8:0]                            cone_conf_i,
  input  logic [9:0]                            cone_left_i,
  input  logic [9:0]                            cone_top_i,
  input  logic [9:0]                            cone_width_i,
  input  logic [9:0]                            cone_height_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  cmd_valid_o,
  output logic [10:0]                           linear_speed_o,
  output logic signed [13:0]                    angular_rate_o,
  output logic [2:0]                            phase_now_o,
  output logic                                  avoiding_o
);
  import lfpc_pkg::*;

  // configuration registers
  logic [10:0]        fwd_speed_q;
  logic signed [12:0] fwd_rate_q;
  logic [15:0]        fwd_ticks_q;
  logic [11:0]        turn_rate_q;
  logic [15:0]        turn_ticks_q;
  logic [8:0]         ythr_q;
  logic [10:0]        fol_speed_q;
  logic [9:0]         fol_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_speed_q  <= RST_FORWARD_SPEED;
      fwd_rate_q   <= RST_FORWARD_RATE;
      fwd_ticks_q  <= RST_FORWARD_TICKS;
      turn_rate_q  <= RST_TURN_RATE;
      turn_ticks_q <= RST_TURN_TICKS;
      ythr_q       <= RST_YELLOW_THRESHOLD;
      fol_speed_q  <= RST_FOLLOW_SPEED;
      fol_gain_q   <= RST_FOLLOW_GAIN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FORWARD_SPEED:    fwd_speed_q  <= cfg_data_i[10:0];
        CFG_FORWARD_RATE:     fwd_rate_q   <= $signed(cfg_data_i[12:0]);
        CFG_FORWARD_TICKS:    fwd_ticks_q  <= cfg_data_i;
        CFG_TURN_RATE:        turn_rate_q  <= cfg_data_i[11:0];
        CFG_TURN_TICKS:       turn_ticks_q <= cfg_data_i;
        CFG_YELLOW_THRESHOLD: ythr_q       <= cfg_data_i[8:0];
        CFG_FOLLOW_SPEED:     fol_speed_q  <= cfg_data_i[10:0];
        CFG_FOLLOW_GAIN:      fol_gain_q   <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // latched input item
  logic               op_q;
  logic signed [10:0] bx_q, yx_q;
  logic               ratio_p_q, cone_p_q;
  logic [8:0]         ratio_q, conf_q;
  logic [9:0]         cl_q, ct_q, cw_q, ch_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= op_i;
      bx_q      <= black_x_i;
      yx_q      <= yellow_x_i;
      ratio_p_q <= ratio_present_i;
      ratio_q   <= yellow_ratio_i;
      cone_p_q  <= cone_present_i;
      conf_q    <= cone_conf_i;
      cl_q      <= cone_left_i;
      ct_q      <= cone_top_i;
      cw_q      <= cone_width_i;
      ch_q      <= cone_height_i;
    end
  end

  // block state
  phase_e             phase_q, phase_d;
  logic [15:0]        tick_q, tick_d;
  logic signed [19:0] line_err_q, avoid_err_q;
  side_e              side_q, side_d;
  logic [1:0]         hold_q, hold_d;

  // per-item working registers
  mode_e       mode_q, mode_d;
  logic        cmd_q, cmd_d;
  logic        avoid_q, avoid_d;
  logic [10:0] spd_q, spd_d;
  logic [20:0] rmag_q, rmag_d;
  logic        rneg_q, rneg_d;
  logic [22:0] num_mag_q;
  logic        num_neg_q;
  logic [20:0] div_q;
  logic        line_clr_d, start_clr_d;

  // detections
  logic        black_ok, yellow_ok, ratio_ok, cone_ok;
  logic [10:0] bottom;
  logic [15:0] tick_bump;
  logic [11:0] cone_sum2;
  logic        side_keep;

  assign black_ok  = !bx_q[10];
  assign yellow_ok = !yx_q[10];
  assign ratio_ok  = ratio_p_q && (ratio_q >= ythr_q);
  assign bottom    = {1'b0, ct_q} + {1'b0, ch_q};
  assign cone_ok   = cone_p_q && (conf_q > CONE_CONF_MIN) &&
                     (bottom >= CONE_BOTTOM_MIN) && (bottom <= CONE_BOTTOM_MAX);
  assign tick_bump = (&tick_q) ? tick_q : tick_q + 16'd1;
  assign cone_sum2 = {1'b0, cl_q, 1'b0} + {2'b00, cw_q};
  assign side_keep = ((side_q == SIDE_LEFT) || (side_q == SIDE_RIGHT)) && (hold_q != 2'd3);

  // search speed: round(3 * follow_speed / 10) by reciprocal
  logic [12:0] search_num;
  logic [25:0] search_prod;
  logic [10:0] search_spd;

  assign search_num  = {2'b00, fol_speed_q} + {1'b0, fol_speed_q, 1'b0} + 13'd5;
  assign search_prod = search_num * RECIP10_16;
  assign search_spd  = {1'b0, search_prod[25:16]};

  // filter numerators, Q8 pixels
  logic signed [11:0] bdiff, ydiff, yerr;
  logic signed [20:0] black_now, avoid_now;
  logic               dead;
  logic signed [23:0] line_err24, avoid_err24, black_num, avoid_num, yellow_num, num;
  logic signed [23:0] bnow24, anow24;

  assign bdiff       = BLACK_TARGET_X - {bx_q[10], bx_q};
  assign black_now   = {bdiff[11], bdiff, 8'b0};
  assign avoid_now   = (side_d == SIDE_LEFT) ?
                       IMG_WIDTH_Q8 - $signed({2'b00, cone_sum2, 7'b0}) :
                       -$signed({2'b00, cone_sum2, 7'b0});
  assign ydiff       = YELLOW_TARGET_X - {yx_q[10], yx_q};
  assign dead        = (ydiff > -DEAD_ZONE) && (ydiff < DEAD_ZONE);
  assign yerr        = dead ? 12'sd0 : ydiff;
  assign line_err24  = {{4{line_err_q[19]}}, line_err_q};
  assign avoid_err24 = {{4{avoid_err_q[19]}}, avoid_err_q};
  assign bnow24      = {{3{black_now[20]}}, black_now};
  assign anow24      = {{3{avoid_now[20]}}, avoid_now};
  // 7 * now + 3 * last
  assign black_num   = (bnow24 <<< 3) - bnow24 + (line_err24 <<< 1) + line_err24;
  assign avoid_num   = (anow24 <<< 3) - anow24 + (avoid_err24 <<< 1) + avoid_err24;
  // now + last, dead zone also drops the last value
  assign yellow_num  = {{4{yerr[11]}}, yerr, 8'b0} + (dead ? 24'sd0 : line_err24);

  always_comb begin
    unique case (mode_d)
      MODE_BLACK:  num = black_num;
      MODE_YELLOW: num = yellow_num;
      MODE_AVOID:  num = avoid_num;
      default:     num = 24'sd0;
    endcase
  end

  // phase decision for one item
  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    side_d      = side_q;
    hold_d      = hold_q;
    mode_d      = MODE_NONE;
    cmd_d       = 1'b0;
    avoid_d     = 1'b0;
    spd_d       = 11'd0;
    rmag_d      = 21'd0;
    rneg_d      = 1'b0;
    line_clr_d  = 1'b0;
    start_clr_d = 1'b0;
    if (op_q) begin
      // start only takes effect from idle
      if (!((phase_q == PH_FORWARD) || (phase_q == PH_TURN) ||
            (phase_q == PH_YELLOW) || (phase_q == PH_BLACK))) begin
        phase_d     = PH_FORWARD;
        tick_d      = 16'd0;
        line_clr_d  = 1'b1;
        start_clr_d = 1'b1;
      end
    end else begin
      unique case (phase_q)
        PH_FORWARD: begin
          cmd_d  = 1'b1;
          spd_d  = fwd_speed_q;
          rneg_d = fwd_rate_q[12];
          rmag_d = {8'd0, fwd_rate_q[12] ? 13'(-fwd_rate_q) : 13'(fwd_rate_q)};
          tick_d = tick_bump;
          if (yellow_ok) begin
            phase_d = PH_YELLOW; tick_d = 16'd0; line_clr_d = 1'b1;
          end else if (black_ok) begin
            phase_d = PH_BLACK; tick_d = 16'd0; line_clr_d = 1'b1;
          end else if (tick_bump >= fwd_ticks_q) begin
            phase_d = PH_TURN; tick_d = 16'd0;
          end
        end
        PH_TURN: begin
          cmd_d  = 1'b1;
          rneg_d = 1'b1;
          rmag_d = {9'd0, turn_rate_q};
          tick_d = tick_bump;
          if (black_ok) begin
            phase_d = PH_BLACK; tick_d = 16'd0; line_clr_d = 1'b1;
          end else if (yellow_ok || ratio_ok) begin
            phase_d = PH_YELLOW; tick_d = 16'd0; line_clr_d = 1'b1;
          end else if (tick_bump >= turn_ticks_q) begin
            // timeout: stop command, back to idle
            rmag_d  = 21'd0;
            phase_d = PH_IDLE;
          end
        end
        PH_YELLOW: begin
          if (black_ok) begin
            phase_d = PH_BLACK; tick_d = 16'd0; line_clr_d = 1'b1;
          end else if (cone_ok) begin
            side_d  = side_keep ? side_q :
                      ((cone_sum2 > CONE_SPLIT_X2) ? SIDE_LEFT : SIDE_RIGHT);
            hold_d  = side_keep ? hold_q + 2'd1 : 2'd0;
            mode_d  = MODE_AVOID;
            cmd_d   = 1'b1;
            avoid_d = 1'b1;
            spd_d   = AVOID_SPEED;
          end else begin
            cmd_d  = 1'b1;
            tick_d = tick_bump;
            if (yellow_ok) begin
              mode_d = MODE_YELLOW;
              spd_d  = fol_speed_q;
            end else begin
              spd_d  = search_spd;
              rneg_d = 1'b1;
              rmag_d = 21'({1'b0, turn_rate_q} + 13'd1) >> 1;
            end
          end
        end
        PH_BLACK: begin
          if (black_ok) begin
            mode_d = MODE_BLACK;
            cmd_d  = 1'b1;
            spd_d  = BLACK_SPEED;
            tick_d = tick_bump;
            if (tick_bump >= SETTLE_TICKS) begin
              phase_d = PH_IDLE; tick_d = 16'd0;
            end
          end else begin
            phase_d = PH_YELLOW; tick_d = 16'd0; line_clr_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // shared divide-by-ten unit, exact floor for arguments below 2^32
  logic [23:0] div_arg;
  logic [55:0] div_prod;

  assign div_arg  = cmd_i.div_rate ? {3'b000, rmag_q} : {1'b0, num_mag_q} + 24'd5;
  assign div_prod = div_arg * RECIP10_32;

  // filtered error: rounded quotient, clamped, signed
  logic [20:0]        filt_mag;
  logic [18:0]        filt_sat;
  logic signed [19:0] filt_err;

  assign filt_mag = (mode_q == MODE_YELLOW) ? 21'(({1'b0, num_mag_q} + 24'd1) >> 1) : div_q;
  assign filt_sat = (filt_mag > {2'b00, ERR_LIMIT}) ? ERR_LIMIT : filt_mag[18:0];
  assign filt_err = num_neg_q ? -$signed({1'b0, filt_sat}) : $signed({1'b0, filt_sat});

  // rate product: gain times filtered error plus rounding bias, divided by 256
  logic signed [19:0] sel_err;
  logic [18:0]        err_mag;
  logic [9:0]         gain;
  logic [28:0]        rate_prod, rate_add;

  assign sel_err   = (mode_q == MODE_AVOID) ? avoid_err_q : line_err_q;
  assign err_mag   = sel_err[19] ? 19'(-sel_err) : sel_err[18:0];
  always_comb begin
    unique case (mode_q)
      MODE_BLACK:  gain = BLACK_GAIN;
      MODE_AVOID:  gain = AVOID_GAIN;
      default:     gain = fol_gain_q;
    endcase
  end
  assign rate_prod = gain * err_mag;
  assign rate_add  = rate_prod + ((mode_q == MODE_BLACK) ? 29'd128 : 29'd1280);

  // state and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= 16'd0;
      line_err_q  <= 20'sd0;
      avoid_err_q <= 20'sd0;
      side_q      <= SIDE_NONE;
      hold_q      <= 2'd0;
      mode_q      <= MODE_NONE;
    end else begin
      if (cmd_i.decide) begin
        phase_q <= phase_d;
        tick_q  <= tick_d;
        side_q  <= side_d;
        hold_q  <= hold_d;
        mode_q  <= mode_d;
        if (line_clr_d)  line_err_q  <= 20'sd0;
        if (start_clr_d) avoid_err_q <= 20'sd0;
      end
      if (cmd_i.filt) begin
        if (mode_q == MODE_AVOID) avoid_err_q <= filt_err;
        else                      line_err_q  <= filt_err;
      end
    end
  end

  // payload of the item in flight
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      cmd_q     <= cmd_d;
      avoid_q   <= avoid_d;
      spd_q     <= spd_d;
      rmag_q    <= rmag_d;
      rneg_q    <= rneg_d;
      num_neg_q <= num[23];
      num_mag_q <= num[23] ? 23'(-num) : num[22:0];
    end
    if (cmd_i.div_run) begin
      div_q <= div_prod[55:35];
    end
    if (cmd_i.rate) begin
      rmag_q <= rate_add[28:8];
      rneg_q <= sel_err[19];
    end
  end

  // final rate: pick quotient or direct magnitude, saturate, apply sign
  logic [20:0]        fin_mag;
  logic [12:0]        fin_sat;
  logic signed [13:0] fin_rate;

  assign fin_mag  = ((mode_q == MODE_YELLOW) || (mode_q == MODE_AVOID)) ? div_q : rmag_q;
  assign fin_sat  = (fin_mag > {8'd0, RATE_LIMIT}) ? RATE_LIMIT : fin_mag[12:0];
  assign fin_rate = rneg_q ? -$signed({1'b0, fin_sat}) : $signed({1'b0, fin_sat});

  // output register
  logic               out_valid_q;
  logic               o_cmd_q, o_avoid_q;
  logic [10:0]        o_spd_q;
  logic signed [13:0] o_rate_q;
  logic [2:0]         o_phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      o_cmd_q   <= cmd_q;
      o_avoid_q <= cmd_q & avoid_q;
      o_spd_q   <= cmd_q ? spd_q : 11'd0;
      o_rate_q  <= cmd_q ? fin_rate : 14'sd0;
      o_phase_q <= phase_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cmd_valid_o    = o_cmd_q;
  assign linear_speed_o = o_spd_q;
  assign angular_rate_o = o_rate_q;
  assign phase_now_o    = o_phase_q;
  assign avoiding_o     = o_avoid_q;

  // status to the controller
  always_comb begin
    status_o.arith    = (mode_d != MODE_NONE);
    status_o.rate_div = (mode_q == MODE_YELLOW) || (mode_q == MODE_AVOID);
    status_o.out_free = !out_valid_q || out_ready_i;
  end

endmodule

>>> hdl/lfpc_checker.sv
// port-level checks of the lane follow phase controller, bound to the top level
// depends on lfpc_pkg and lane_follow_phase_controller_defines.svh
`include "lane_follow_phase_controller_defines.svh"

module lfpc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            cmd_valid_o,
  input logic [10:0]                     linear_speed_o,
  input logic signed [13:0]              angular_rate_o,
  input logic [2:0]                      phase_now_o,
  input logic                            avoiding_o
);
  import lfpc_pkg::*;

  // a stalled result holds
  `LFPC_ASSERT_CLK(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(angular_rate_o) && $stable(linear_speed_o) && $stable(phase_now_o)), "stalled result changed")

  // one item in work at a time
  `LFPC_ASSERT_CLK(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "item taken while busy")

  // no command means a zero payload
  `LFPC_ASSERT_CLK(a_no_cmd_zero, (out_valid_o && !cmd_valid_o) |-> (linear_speed_o == 11'd0 && angular_rate_o == 14'sd0 && !avoiding_o), "payload without command")

  // yaw rate stays saturated
  `LFPC_ASSERT_CLK(a_rate_limit, out_valid_o |-> (angular_rate_o <= 14'sd8000 && angular_rate_o >= -14'sd8000), "rate beyond limit")

  // avoidance only from yellow follow at avoid speed
  `LFPC_ASSERT_CLK(a_avoid_phase, (out_valid_o && avoiding_o) |-> (phase_now_o == PH_YELLOW && linear_speed_o == AVOID_SPEED), "avoid outside yellow follow")

endmodule

bind lane_follow_phase_controller lfpc_checker u_lfpc_checker (.*);
